>>> rtl/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types and constants for the nearest palette color search.
// ----------------------------------------------------------------------------
package npc_pkg;

  localparam int NPC_PALETTE_DEPTH = 256;
  localparam int NPC_CHANNEL_BITS  = 8;

  // Fixed widths of the channel payload fields.
  localparam int FIELD_BITS      = 8;
  localparam int COUNT_BITS      = 9;
  localparam int DIST_FIELD_BITS = 18;

  localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // Control that travels with every item along the cell chain.
  typedef struct packed {
    logic valid;
    op_t  op;
  } cell_ctl_t;

endpackage

>>> rtl/npc_if.sv
// ----------------------------------------------------------------------------
// npc_request_if / npc_result_if
// Valid/ready channels for palette writes and queries, and for query results.
// ----------------------------------------------------------------------------
interface npc_request_if;
  logic                             valid;
  logic                             ready;
  logic                             op;
  logic [npc_pkg::FIELD_BITS-1:0]   entry_index;
  logic [npc_pkg::FIELD_BITS-1:0]   red;
  logic [npc_pkg::FIELD_BITS-1:0]   green;
  logic [npc_pkg::FIELD_BITS-1:0]   blue;

  modport source (output valid, op, entry_index, red, green, blue, input ready);
  modport sink   (input valid, op, entry_index, red, green, blue, output ready);
endinterface

interface npc_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [npc_pkg::FIELD_BITS-1:0]        best_index;
  logic [npc_pkg::FIELD_BITS-1:0]        best_red;
  logic [npc_pkg::FIELD_BITS-1:0]        best_green;
  logic [npc_pkg::FIELD_BITS-1:0]        best_blue;
  logic [npc_pkg::DIST_FIELD_BITS-1:0]   nearest_dist;

  modport source (output valid, best_index, best_red, best_green, best_blue,
                  nearest_dist, input ready);
  modport sink   (input valid, best_index, best_red, best_green, best_blue,
                  nearest_dist, output ready);
endinterface

>>> rtl/npc_cell.sv
// ----------------------------------------------------------------------------
// npc_cell
// One palette cell: holds one entry, squares the channel differences of a
// passing query in its first stage and updates the running best in its second.
// ----------------------------------------------------------------------------
module npc_cell #(
  parameter int PALETTE_DEPTH = npc_pkg::NPC_PALETTE_DEPTH,
  parameter int CHANNEL_BITS  = npc_pkg::NPC_CHANNEL_BITS,
  parameter int CELL_INDEX    = 0
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          en,
  input  logic [npc_pkg::COUNT_BITS-1:0]                count,
  input  npc_pkg::cell_ctl_t                            ctl_in,
  input  logic [npc_pkg::FIELD_BITS-1:0]                idx_in,
  input  logic [2:0][CHANNEL_BITS-1:0]                  pix_in,
  input  logic [$clog2(PALETTE_DEPTH)-1:0]              best_idx_in,
  input  logic [2:0][CHANNEL_BITS-1:0]                  best_col_in,
  input  logic [2*CHANNEL_BITS+1:0]                     best_dist_in,
  output npc_pkg::cell_ctl_t                            ctl_out,
  output logic [npc_pkg::FIELD_BITS-1:0]                idx_out,
  output logic [2:0][CHANNEL_BITS-1:0]                  pix_out,
  output logic [$clog2(PALETTE_DEPTH)-1:0]              best_idx_out,
  output logic [2:0][CHANNEL_BITS-1:0]                  best_col_out,
  output logic [2*CHANNEL_BITS+1:0]                     best_dist_out
);

  localparam int CB = CHANNEL_BITS;
  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int DW = 2 * CHANNEL_BITS + 2;
  localparam int SW = 2 * CHANNEL_BITS;
  localparam bit WRITABLE  = CELL_INDEX < (1 << npc_pkg::FIELD_BITS);
  localparam bit COUNTABLE = CELL_INDEX < (1 << npc_pkg::COUNT_BITS);
  localparam logic [npc_pkg::FIELD_BITS-1:0] OWN_SLOT  = npc_pkg::FIELD_BITS'(CELL_INDEX);
  localparam logic [npc_pkg::COUNT_BITS-1:0] OWN_COUNT = npc_pkg::COUNT_BITS'(CELL_INDEX);
  localparam logic [IW-1:0]                  OWN_IDX   = IW'(CELL_INDEX);

  logic [2:0][CB-1:0] entry;

  // First stage registers.
  npc_pkg::cell_ctl_t              a_ctl;
  logic [npc_pkg::FIELD_BITS-1:0]  a_idx;
  logic [2:0][CB-1:0]              a_pix;
  logic [2:0][CB-1:0]              a_col;
  logic [2:0][SW-1:0]              a_sq;
  logic [IW-1:0]                   a_best_idx;
  logic [2:0][CB-1:0]              a_best_col;
  logic [DW-1:0]                   a_best_dist;

  logic               write_hit;
  logic [2:0][CB-1:0] diff;
  logic [2:0][SW-1:0] sq;
  logic [DW-1:0]      cand_dist;
  logic               active;
  logic               take;

  assign write_hit = WRITABLE && ctl_in.valid && (ctl_in.op == npc_pkg::OP_WRITE) &&
                     (idx_in == OWN_SLOT);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (entry[c] > pix_in[c]) ? (entry[c] - pix_in[c]) : (pix_in[c] - entry[c]);
      sq[c]   = {{CB{1'b0}}, diff[c]} * {{CB{1'b0}}, diff[c]};
    end
  end

  // Writes travel the chain in order with queries, so a query sees exactly the
  // writes that were transferred before it.
  always_ff @(posedge clk) begin
    if (en && write_hit) begin
      entry <= pix_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (en) begin
      a_ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx       <= idx_in;
      a_pix       <= pix_in;
      a_col       <= entry;
      a_sq        <= sq;
      a_best_idx  <= best_idx_in;
      a_best_col  <= best_col_in;
      a_best_dist <= best_dist_in;
    end
  end

  // Entry zero always takes part, which also covers a count of zero.
  assign active    = (CELL_INDEX == 0) || (COUNTABLE && (OWN_COUNT < count));
  assign cand_dist = DW'(a_sq[0]) + DW'(a_sq[1]) + DW'(a_sq[2]);
  assign take      = active && (a_ctl.op == npc_pkg::OP_QUERY) &&
                     ((CELL_INDEX == 0) || (cand_dist < a_best_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= a_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_out <= a_idx;
      pix_out <= a_pix;
      if (take) begin
        best_idx_out  <= OWN_IDX;
        best_col_out  <= a_col;
        best_dist_out <= cand_dist;
      end else begin
        best_idx_out  <= a_best_idx;
        best_col_out  <= a_best_col;
        best_dist_out <= a_best_dist;
      end
    end
  end

endmodule

>>> rtl/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color
// Brute-force nearest palette color search over a row of palette cells.
// ----------------------------------------------------------------------------
// Pipeline: two register stages per palette cell from request transfer to result.
// Throughput: one write or query per cycle; the whole row stalls only while a
// finished result waits at the output.
// Reset clears the item valid flags and sets palette_count to 1; the palette
// entries hold no reset value and read as undefined until written.
module nearest_palette_color #(
  parameter int PALETTE_DEPTH = npc_pkg::NPC_PALETTE_DEPTH,
  parameter int CHANNEL_BITS  = npc_pkg::NPC_CHANNEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  npc_request_if.sink                    request,
  npc_result_if.source                   result,
  input  logic                           cfg_we,
  input  logic [npc_pkg::COUNT_BITS-1:0] cfg_wdata
);

  localparam int CB = CHANNEL_BITS;
  localparam int IW = $clog2(PALETTE_DEPTH);
  localparam int DW = 2 * CHANNEL_BITS + 2;
  localparam int FB = npc_pkg::FIELD_BITS;
  localparam int OB = npc_pkg::DIST_FIELD_BITS;

  logic [npc_pkg::COUNT_BITS-1:0] palette_count;

  npc_pkg::cell_ctl_t [PALETTE_DEPTH:0]          chain_ctl;
  logic [PALETTE_DEPTH:0][FB-1:0]                chain_idx;
  logic [PALETTE_DEPTH:0][2:0][CB-1:0]           chain_pix;
  logic [PALETTE_DEPTH:0][IW-1:0]                chain_best_idx;
  logic [PALETTE_DEPTH:0][2:0][CB-1:0]           chain_best_col;
  logic [PALETTE_DEPTH:0][DW-1:0]                chain_best_dist;

  logic                 advance;
  logic                 last_query;
  logic [CB+FB-1:0]     in_red;
  logic [CB+FB-1:0]     in_green;
  logic [CB+FB-1:0]     in_blue;
  logic [IW+FB-1:0]     out_idx;
  logic [CB+FB-1:0]     out_red;
  logic [CB+FB-1:0]     out_green;
  logic [CB+FB-1:0]     out_blue;
  logic [DW+OB-1:0]     out_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_count <= npc_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      palette_count <= cfg_wdata;
    end
  end

  // The row moves as one; it holds only while a result is not taken.
  assign last_query = chain_ctl[PALETTE_DEPTH].valid &&
                      (chain_ctl[PALETTE_DEPTH].op == npc_pkg::OP_QUERY);
  assign advance    = !last_query || result.ready;
  assign request.ready = advance;

  assign in_red   = {{CB{1'b0}}, request.red};
  assign in_green = {{CB{1'b0}}, request.green};
  assign in_blue  = {{CB{1'b0}}, request.blue};

  assign chain_ctl[0].valid  = request.valid;
  assign chain_ctl[0].op     = npc_pkg::op_t'(request.op);
  assign chain_idx[0]        = request.entry_index;
  assign chain_pix[0][0]     = in_red[CB-1:0];
  assign chain_pix[0][1]     = in_green[CB-1:0];
  assign chain_pix[0][2]     = in_blue[CB-1:0];
  assign chain_best_idx[0]   = '0;
  assign chain_best_col[0]   = '0;
  assign chain_best_dist[0]  = '0;

  for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
    npc_cell #(
      .PALETTE_DEPTH (PALETTE_DEPTH),
      .CHANNEL_BITS  (CHANNEL_BITS),
      .CELL_INDEX    (k)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .en            (advance),
      .count         (palette_count),
      .ctl_in        (chain_ctl[k]),
      .idx_in        (chain_idx[k]),
      .pix_in        (chain_pix[k]),
      .best_idx_in   (chain_best_idx[k]),
      .best_col_in   (chain_best_col[k]),
      .best_dist_in  (chain_best_dist[k]),
      .ctl_out       (chain_ctl[k+1]),
      .idx_out       (chain_idx[k+1]),
      .pix_out       (chain_pix[k+1]),
      .best_idx_out  (chain_best_idx[k+1]),
      .best_col_out  (chain_best_col[k+1]),
      .best_dist_out (chain_best_dist[k+1])
    );
  end

  assign out_idx   = {{FB{1'b0}}, chain_best_idx[PALETTE_DEPTH]};
  assign out_red   = {{FB{1'b0}}, chain_best_col[PALETTE_DEPTH][0]};
  assign out_green = {{FB{1'b0}}, chain_best_col[PALETTE_DEPTH][1]};
  assign out_blue  = {{FB{1'b0}}, chain_best_col[PALETTE_DEPTH][2]};
  assign out_dist  = {{OB{1'b0}}, chain_best_dist[PALETTE_DEPTH]};

  // Writes leave the end of the row silently; only queries make a transfer.
  assign result.valid        = last_query;
  assign result.best_index   = out_idx[FB-1:0];
  assign result.best_red     = out_red[FB-1:0];
  assign result.best_green   = out_green[FB-1:0];
  assign result.best_blue    = out_blue[FB-1:0];
  assign result.nearest_dist = out_dist[OB-1:0];

endmodule
